FILE: rtl/ftpap_pkg.sv
`timescale 1ns / 1ps

package ftpap_pkg;

  // Argument kinds, taken from the first byte of a payload
  localparam logic [1:0] OP_PORT = 2'd0;
  localparam logic [1:0] OP_EPRT = 2'd1;
  localparam logic [1:0] OP_PASV = 2'd2;
  localparam logic [1:0] OP_EPSV = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_COUNTED = 2'd1;
  localparam logic [1:0] ST_FAIL    = 2'd2;
  localparam logic [1:0] ST_IPV6    = 2'd3;

  // Characters
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] DELIM_LO = 8'd33;
  localparam logic [7:0] DELIM_HI = 8'd126;

  localparam logic [2:0] LIST_FIELDS = 3'd6;
  localparam logic [2:0] ADDR_FIELDS = 3'd4;
  localparam logic [2:0] LAST_LIST   = 3'd5;
  localparam logic [2:0] LAST_ADDR   = 3'd3;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_PORT_NUM  = 4'd1,
    PH_PASV_SKIP = 4'd2,
    PH_PASV_NUM  = 4'd3,
    PH_EPRT_HEAD = 4'd4,
    PH_EPRT_ADDR = 4'd5,
    PH_EPRT_PORT = 4'd6,
    PH_EPSV_HEAD = 4'd7,
    PH_EPSV_PORT = 4'd8,
    PH_DONE_SIX  = 4'd9,
    PH_DONE_EPRT = 4'd10,
    PH_DONE_EPSV = 4'd11,
    PH_DONE_FAIL = 4'd12
  } phase_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic [1:0] operation;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        address_valid;
    logic [31:0] ip_address;
    logic [15:0] port_number;
    logic [31:0] error_total;
  } out_item_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic delim_ok(input logic [7:0] c);
    return !is_digit(c) && (c >= DELIM_LO) && (c <= DELIM_HI);
  endfunction

  // x*10 + d as two shifts and adds
  function automatic logic [31:0] mac10_32(input logic [31:0] x, input logic [3:0] d);
    return (x << 3) + (x << 1) + {28'd0, d};
  endfunction

  function automatic logic [15:0] mac10_16(input logic [15:0] x, input logic [3:0] d);
    return (x << 3) + (x << 1) + {12'd0, d};
  endfunction

endpackage

FILE: rtl/ftpap_in_stage.sv
`timescale 1ns / 1ps

module ftpap_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid,
  output logic               stall,
  input  ftpap_pkg::in_item_t data,
  input  logic               take,
  output logic               full,
  output ftpap_pkg::in_item_t item
);

  logic accept;
  logic full_next;

  assign stall     = full && !take;
  assign accept    = valid && !stall;
  assign full_next = accept || (full && !take);

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      full <= full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= data;
    end
  end

endmodule

FILE: rtl/ftpap_parser.sv
`timescale 1ns / 1ps

module ftpap_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  ftpap_pkg::in_item_t  item,
  output ftpap_pkg::out_item_t result
);

  // Parse state
  ftpap_pkg::phase_t phase, phase_next;
  logic [2:0]  field_index, field_index_next;
  logic [15:0] port_acc, port_acc_next;
  logic [7:0]  delim, delim_next;
  logic [1:0]  byte_pos, byte_pos_next;
  logic [1:0]  outcome, outcome_next;
  logic [31:0] err_count, err_count_next;

  // Decimal fields, only the bits that reach the result are kept
  logic [31:0] n0, n0_next;
  logic [23:0] n1, n1_next;
  logic [15:0] n2, n2_next;
  logic [7:0]  n3, n3_next;
  logic [15:0] n4, n4_next;
  logic [7:0]  n5, n5_next;

  logic [7:0]  c;
  logic [3:0]  d;
  logic        digit;
  logic        start;
  logic        wr_field;
  logic        run_list;
  logic        cr_only;
  logic [31:0] sel;
  logic [31:0] acc;
  logic [1:0]  st;
  logic        addr_ok;
  logic [31:0] ip;
  logic [15:0] port;

  assign c     = item.byte_value;
  assign d     = c[3:0];
  assign digit = ftpap_pkg::is_digit(c);
  assign start = (phase == ftpap_pkg::PH_IDLE) || (phase > ftpap_pkg::PH_DONE_FAIL);

  always_comb begin
    phase_next       = phase;
    field_index_next = field_index;
    port_acc_next    = port_acc;
    delim_next       = delim;
    byte_pos_next    = byte_pos;
    outcome_next     = outcome;
    n0_next = n0;
    n1_next = n1;
    n2_next = n2;
    n3_next = n3;
    n4_next = n4;
    n5_next = n5;
    wr_field = 1'b0;
    run_list = 1'b0;
    cr_only  = 1'b0;

    if (start) begin
      field_index_next = '0;
      port_acc_next    = '0;
      delim_next       = '0;
      byte_pos_next    = '0;
      outcome_next     = '0;
      n0_next = '0;
      n1_next = '0;
      n2_next = '0;
      n3_next = '0;
      n4_next = '0;
      n5_next = '0;
      case (item.operation)
        ftpap_pkg::OP_PORT: phase_next = ftpap_pkg::PH_PORT_NUM;
        ftpap_pkg::OP_EPRT: phase_next = ftpap_pkg::PH_EPRT_HEAD;
        ftpap_pkg::OP_PASV: phase_next = ftpap_pkg::PH_PASV_SKIP;
        default:            phase_next = ftpap_pkg::PH_EPSV_HEAD;
      endcase
    end

    case (phase_next)
      ftpap_pkg::PH_PORT_NUM: begin
        run_list = 1'b1;
        cr_only  = 1'b1;
      end
      ftpap_pkg::PH_PASV_SKIP: begin
        if (digit) begin
          phase_next = ftpap_pkg::PH_PASV_NUM;
          run_list   = 1'b1;
        end
      end
      ftpap_pkg::PH_PASV_NUM: begin
        run_list = 1'b1;
      end
      ftpap_pkg::PH_EPRT_HEAD: begin
        if (byte_pos_next == 2'd0) begin
          delim_next = c;
          if (!ftpap_pkg::delim_ok(c)) begin
            phase_next   = ftpap_pkg::PH_DONE_FAIL;
            outcome_next = ftpap_pkg::ST_COUNTED;
          end else begin
            byte_pos_next = 2'd1;
          end
        end else if (byte_pos_next == 2'd1) begin
          if (c == ftpap_pkg::CH_ONE) begin
            outcome_next  = ftpap_pkg::ST_OK;
            byte_pos_next = 2'd2;
          end else if (c == ftpap_pkg::CH_TWO) begin
            outcome_next  = ftpap_pkg::ST_IPV6;
            byte_pos_next = 2'd2;
          end else begin
            phase_next   = ftpap_pkg::PH_DONE_FAIL;
            outcome_next = ftpap_pkg::ST_COUNTED;
          end
        end else begin
          if (c != delim_next || item.last_byte) begin
            phase_next   = ftpap_pkg::PH_DONE_FAIL;
            outcome_next = ftpap_pkg::ST_COUNTED;
          end else if (outcome_next == ftpap_pkg::ST_IPV6) begin
            phase_next   = ftpap_pkg::PH_DONE_FAIL;
            outcome_next = ftpap_pkg::ST_IPV6;
          end else begin
            phase_next       = ftpap_pkg::PH_EPRT_ADDR;
            field_index_next = '0;
          end
        end
      end
      ftpap_pkg::PH_EPRT_ADDR: begin
        if (digit) begin
          wr_field = (field_index_next < ftpap_pkg::ADDR_FIELDS);
        end else if (c == ftpap_pkg::CH_DOT) begin
          field_index_next = field_index_next + 3'd1;
          if (field_index_next >= ftpap_pkg::ADDR_FIELDS) begin
            phase_next   = ftpap_pkg::PH_DONE_FAIL;
            outcome_next = ftpap_pkg::ST_COUNTED;
          end
        end else if (c == delim_next && field_index_next == ftpap_pkg::LAST_ADDR) begin
          phase_next    = ftpap_pkg::PH_EPRT_PORT;
          port_acc_next = '0;
        end else begin
          phase_next   = ftpap_pkg::PH_DONE_FAIL;
          outcome_next = ftpap_pkg::ST_COUNTED;
        end
      end
      ftpap_pkg::PH_EPSV_HEAD: begin
        if (byte_pos_next == 2'd0) begin
          delim_next = c;
          if (!ftpap_pkg::delim_ok(c)) begin
            phase_next   = ftpap_pkg::PH_DONE_FAIL;
            outcome_next = ftpap_pkg::ST_FAIL;
          end else begin
            byte_pos_next = 2'd1;
          end
        end else if (byte_pos_next == 2'd1) begin
          if (c != delim_next) begin
            phase_next   = ftpap_pkg::PH_DONE_FAIL;
            outcome_next = ftpap_pkg::ST_FAIL;
          end else begin
            byte_pos_next = 2'd2;
          end
        end else begin
          if (c != delim_next || item.last_byte) begin
            phase_next   = ftpap_pkg::PH_DONE_FAIL;
            outcome_next = ftpap_pkg::ST_FAIL;
          end else begin
            phase_next    = ftpap_pkg::PH_EPSV_PORT;
            port_acc_next = '0;
          end
        end
      end
      ftpap_pkg::PH_EPRT_PORT, ftpap_pkg::PH_EPSV_PORT: begin
        if (c == delim_next) begin
          if (port_acc_next == 16'd0) begin
            outcome_next = (phase_next == ftpap_pkg::PH_EPRT_PORT) ?
                           ftpap_pkg::ST_COUNTED : ftpap_pkg::ST_FAIL;
            phase_next   = ftpap_pkg::PH_DONE_FAIL;
          end else begin
            phase_next = (phase_next == ftpap_pkg::PH_EPRT_PORT) ?
                         ftpap_pkg::PH_DONE_EPRT : ftpap_pkg::PH_DONE_EPSV;
          end
        end else if (digit) begin
          port_acc_next = ftpap_pkg::mac10_16(port_acc_next, d);
        end else begin
          outcome_next = (phase_next == ftpap_pkg::PH_EPRT_PORT) ?
                         ftpap_pkg::ST_COUNTED : ftpap_pkg::ST_FAIL;
          phase_next   = ftpap_pkg::PH_DONE_FAIL;
        end
      end
      default: begin
      end
    endcase

    // comma list shared by PORT and PASV
    if (run_list) begin
      if (digit) begin
        wr_field = (field_index_next < ftpap_pkg::LIST_FIELDS);
      end else if (c == ftpap_pkg::CH_COMMA) begin
        field_index_next = field_index_next + 3'd1;
        if (field_index_next >= ftpap_pkg::LIST_FIELDS) begin
          phase_next   = ftpap_pkg::PH_DONE_FAIL;
          outcome_next = ftpap_pkg::ST_COUNTED;
        end
      end else if ((!cr_only || c == ftpap_pkg::CH_CR) &&
                   field_index_next == ftpap_pkg::LAST_LIST) begin
        phase_next = ftpap_pkg::PH_DONE_SIX;
      end else begin
        phase_next   = ftpap_pkg::PH_DONE_FAIL;
        outcome_next = ftpap_pkg::ST_COUNTED;
      end
    end

    // one shared x10 accumulate for the selected field
    case (field_index_next)
      3'd0:    sel = n0_next;
      3'd1:    sel = {8'd0, n1_next};
      3'd2:    sel = {16'd0, n2_next};
      3'd3:    sel = {24'd0, n3_next};
      3'd4:    sel = {16'd0, n4_next};
      default: sel = {24'd0, n5_next};
    endcase
    acc = ftpap_pkg::mac10_32(sel, d);

    if (wr_field) begin
      case (field_index_next)
        3'd0:    n0_next = acc;
        3'd1:    n1_next = acc[23:0];
        3'd2:    n2_next = acc[15:0];
        3'd3:    n3_next = acc[7:0];
        3'd4:    n4_next = acc[15:0];
        default: n5_next = acc[7:0];
      endcase
    end
  end

  // Result for the byte marked last
  assign ip = n0_next | {n1_next, 8'd0} | {n2_next, 16'd0} | {n3_next, 24'd0};

  always_comb begin
    st      = ftpap_pkg::ST_OK;
    addr_ok = 1'b0;
    port    = '0;
    case (phase_next)
      ftpap_pkg::PH_DONE_SIX: begin
        addr_ok = 1'b1;
        port    = n4_next | {n5_next, 8'd0};
      end
      ftpap_pkg::PH_DONE_EPRT: begin
        addr_ok = 1'b1;
        port    = port_acc_next;
      end
      ftpap_pkg::PH_DONE_EPSV: begin
        port = port_acc_next;
      end
      ftpap_pkg::PH_DONE_FAIL: begin
        st = outcome_next;
      end
      ftpap_pkg::PH_PASV_SKIP, ftpap_pkg::PH_EPSV_HEAD, ftpap_pkg::PH_EPSV_PORT: begin
        st = ftpap_pkg::ST_FAIL;
      end
      default: begin
        st = ftpap_pkg::ST_COUNTED;
      end
    endcase
    err_count_next = err_count + {31'd0, (st == ftpap_pkg::ST_COUNTED)};
  end

  assign result.status        = st;
  assign result.address_valid = addr_ok;
  assign result.ip_address    = addr_ok ? ip : 32'd0;
  assign result.port_number   = port;
  assign result.error_total   = err_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= ftpap_pkg::PH_IDLE;
      field_index <= '0;
      port_acc    <= '0;
      delim       <= '0;
      byte_pos    <= '0;
      outcome     <= '0;
      err_count   <= '0;
    end else if (step) begin
      phase       <= item.last_byte ? ftpap_pkg::PH_IDLE : phase_next;
      field_index <= field_index_next;
      port_acc    <= port_acc_next;
      delim       <= delim_next;
      byte_pos    <= byte_pos_next;
      outcome     <= outcome_next;
      if (item.last_byte) begin
        err_count <= err_count_next;
      end
    end
  end

  // fields are cleared at the start of every payload
  always_ff @(posedge clk) begin
    if (step) begin
      n0 <= n0_next;
      n1 <= n1_next;
      n2 <= n2_next;
      n3 <= n3_next;
      n4 <= n4_next;
      n5 <= n5_next;
    end
  end

endmodule

FILE: rtl/ftpap_out_stage.sv
`timescale 1ns / 1ps

module ftpap_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  ftpap_pkg::out_item_t result,
  output logic                 room,
  output logic                 valid,
  input  logic                 stall,
  output ftpap_pkg::out_item_t data
);

  logic valid_next;

  assign room       = !valid || !stall;
  assign valid_next = load || (valid && stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= result;
    end
  end

endmodule

FILE: rtl/ftp_address_port_parser_top.sv
`timescale 1ns / 1ps

// FTP PORT / PASV / EPRT / EPSV argument parser.
// byte channel: one argument byte per item with its kind (taken from the
// first byte of a payload) and an end marker. result channel: one item per
// payload, on its last byte: status, IPv4 address, port and the running
// parse error count.
// Result path: an accepted byte is loaded into the input register; when a
// last byte is taken from it, the result register loads and result_valid
// rises. That take waits while a held result is stalled.
// Throughput: one byte per cycle, also while a result waits, except a last
// byte behind a stalled result; per byte, one x10 accumulate and compare.
// Stall: byte_stall rises only when a last byte sits in the input register
// while the result register is full and result_stall is high. Non-last
// bytes keep flowing behind a stalled result.
// Reset: clears the parse state and the error count; no result is pending
// afterwards and the next byte starts a new payload.

module ftp_address_port_parser_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_stall,
  input  ftpap_pkg::in_item_t  byte_data,
  output logic                 result_valid,
  input  logic                 result_stall,
  output ftpap_pkg::out_item_t result_data
);

  logic                 full;
  logic                 room;
  logic                 take;
  ftpap_pkg::in_item_t  item;
  ftpap_pkg::out_item_t result;

  assign take = full && (!item.last_byte || room);

  ftpap_in_stage u_in_stage (
    .clk   (clk),
    .rst   (rst),
    .valid (byte_valid),
    .stall (byte_stall),
    .data  (byte_data),
    .take  (take),
    .full  (full),
    .item  (item)
  );

  ftpap_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (take),
    .item   (item),
    .result (result)
  );

  ftpap_out_stage u_out_stage (
    .clk    (clk),
    .rst    (rst),
    .load   (take && item.last_byte),
    .result (result),
    .room   (room),
    .valid  (result_valid),
    .stall  (result_stall),
    .data   (result_data)
  );

endmodule

FILE: rtl/ftpap_checker.sv
`timescale 1ns / 1ps

module ftpap_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 byte_stall,
  input logic                 result_valid,
  input logic                 result_stall,
  input ftpap_pkg::out_item_t result_data
);

  // held result stays put
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result_data))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result pending after reset");

  // input only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> result_valid && result_stall)
    else $error("byte channel stalled without a stalled result");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.status != ftpap_pkg::ST_OK |->
      !result_data.address_valid && result_data.ip_address == 32'd0 &&
      result_data.port_number == 16'd0)
    else $error("failed parse carries address or port");

  a_addr_ok: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_data.address_valid |-> result_data.ip_address == 32'd0)
    else $error("address without address_valid");

endmodule

bind ftp_address_port_parser_top ftpap_checker u_checker (.*);

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ftpap_pkg::*;

  localparam int          LIMIT_CYCLES = 400000;
  localparam int          HOLD_CYCLES  = 400;
  localparam logic [7:0]  CH_BAR       = 8'h7C;
  localparam logic [7:0]  CH_LPAREN    = 8'h28;
  localparam logic [7:0]  CH_RPAREN    = 8'h29;

  class addr_port_scoreboard;
    phase_t      ph;
    logic [31:0] fld [6];
    logic [2:0]  fidx;
    logic [15:0] pacc;
    logic [7:0]  dlm;
    logic [1:0]  bpos;
    logic [1:0]  why;
    logic [31:0] err_count;
    out_item_t   due_results [$];
    int          mismatches;
    int          results_seen;
    int          status_hits [4];

    function new();
      clear_parse();
      err_count    = '0;
      mismatches   = 0;
      results_seen = 0;
      foreach (status_hits[k]) status_hits[k] = 0;
    endfunction

    function void clear_parse();
      ph   = PH_IDLE;
      foreach (fld[k]) fld[k] = '0;
      fidx = '0;
      pacc = '0;
      dlm  = '0;
      bpos = '0;
      why  = ST_OK;
    endfunction

    function bit dec_char(logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function bit head_delim(logic [7:0] c);
      return !dec_char(c) && (c >= DELIM_LO) && (c <= DELIM_HI);
    endfunction

    function void fail(logic [1:0] s);
      ph  = PH_DONE_FAIL;
      why = s;
    endfunction

    // comma-separated six-number list (PORT, PASV)
    function void list_byte(logic [7:0] c, bit cr_only);
      if (dec_char(c)) begin
        if (fidx < LIST_FIELDS) fld[fidx] = fld[fidx] * 32'd10 + {24'd0, c - CH_ZERO};
      end else if (c == CH_COMMA) begin
        fidx = fidx + 3'd1;
        if (fidx >= LIST_FIELDS) fail(ST_COUNTED);
      end else if ((!cr_only || c == CH_CR) && fidx == LAST_LIST) begin
        ph = PH_DONE_SIX;
      end else begin
        fail(ST_COUNTED);
      end
    endfunction

    function void port_byte(logic [7:0] c, phase_t done, logic [1:0] err);
      if (c == dlm) begin
        if (pacc == 16'd0) fail(err);
        else ph = done;
      end else if (dec_char(c)) begin
        pacc = pacc * 16'd10 + {8'd0, c - CH_ZERO};
      end else begin
        fail(err);
      end
    endfunction

    // advance the parse by one accepted byte; queue a result on the last byte
    function void take_byte(in_item_t it);
      logic [7:0]  c;
      bit          fin;
      logic [31:0] ip4;
      logic [31:0] pw;
      out_item_t   r;
      c   = it.byte_value;
      fin = it.last_byte;
      if (ph == PH_IDLE) begin
        clear_parse();
        case (it.operation)
          OP_PORT: ph = PH_PORT_NUM;
          OP_EPRT: ph = PH_EPRT_HEAD;
          OP_PASV: ph = PH_PASV_SKIP;
          default: ph = PH_EPSV_HEAD;
        endcase
      end
      case (ph)
        PH_PORT_NUM: list_byte(c, 1'b1);
        PH_PASV_SKIP: begin
          if (dec_char(c)) begin
            ph = PH_PASV_NUM;
            list_byte(c, 1'b0);
          end
        end
        PH_PASV_NUM: list_byte(c, 1'b0);
        PH_EPRT_HEAD: begin
          if (bpos == 2'd0) begin
            dlm = c;
            if (!head_delim(c)) fail(ST_COUNTED);
            else bpos = 2'd1;
          end else if (bpos == 2'd1) begin
            if (c == CH_ONE) begin
              why  = ST_OK;
              bpos = 2'd2;
            end else if (c == CH_TWO) begin
              why  = ST_IPV6;
              bpos = 2'd2;
            end else begin
              fail(ST_COUNTED);
            end
          end else if (c != dlm || fin) begin
            fail(ST_COUNTED);
          end else if (why == ST_IPV6) begin
            fail(ST_IPV6);
          end else begin
            ph   = PH_EPRT_ADDR;
            fidx = '0;
          end
        end
        PH_EPRT_ADDR: begin
          if (dec_char(c)) begin
            if (fidx < ADDR_FIELDS) fld[fidx] = fld[fidx] * 32'd10 + {24'd0, c - CH_ZERO};
          end else if (c == CH_DOT) begin
            fidx = fidx + 3'd1;
            if (fidx >= ADDR_FIELDS) fail(ST_COUNTED);
          end else if (c == dlm && fidx == LAST_ADDR) begin
            ph   = PH_EPRT_PORT;
            pacc = '0;
          end else begin
            fail(ST_COUNTED);
          end
        end
        PH_EPRT_PORT: port_byte(c, PH_DONE_EPRT, ST_COUNTED);
        PH_EPSV_HEAD: begin
          if (bpos == 2'd0) begin
            dlm = c;
            if (!head_delim(c)) fail(ST_FAIL);
            else bpos = 2'd1;
          end else if (bpos == 2'd1) begin
            if (c != dlm) fail(ST_FAIL);
            else bpos = 2'd2;
          end else if (c != dlm || fin) begin
            fail(ST_FAIL);
          end else begin
            ph   = PH_EPSV_PORT;
            pacc = '0;
          end
        end
        PH_EPSV_PORT: port_byte(c, PH_DONE_EPSV, ST_FAIL);
        default: ;
      endcase
      if (!fin) return;

      ip4 = (fld[3] << 24) | (fld[2] << 16) | (fld[1] << 8) | fld[0];
      pw  = (fld[5] << 8) | fld[4];
      r   = '0;
      r.status = ST_OK;
      case (ph)
        PH_DONE_SIX: begin
          r.address_valid = 1'b1;
          r.ip_address    = ip4;
          r.port_number   = pw[15:0];
        end
        PH_DONE_EPRT: begin
          r.address_valid = 1'b1;
          r.ip_address    = ip4;
          r.port_number   = pacc;
        end
        PH_DONE_EPSV: r.port_number = pacc;
        PH_DONE_FAIL: r.status = why;
        PH_PASV_SKIP, PH_EPSV_HEAD, PH_EPSV_PORT: r.status = ST_FAIL;
        default: r.status = ST_COUNTED;
      endcase
      if (r.status == ST_COUNTED) err_count = err_count + 32'd1;
      r.error_total = err_count;
      due_results.push_back(r);
      clear_parse();
    endfunction

    task report_mismatch(string what, out_item_t want, out_item_t got);
      $display({"MISMATCH %s: want st=%0d av=%0d ip=%h port=%0d err=%0d",
                " got st=%0d av=%0d ip=%h port=%0d err=%0d"},
               what, want.status, want.address_valid, want.ip_address, want.port_number,
               want.error_total, got.status, got.address_valid, got.ip_address,
               got.port_number, got.error_total);
      mismatches++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      status_hits[got.status]++;
      if (due_results.size() == 0) begin
        report_mismatch("unexpected result", '0, got);
        return;
      end
      want = due_results.pop_front();
      if (got.status != want.status || got.address_valid != want.address_valid ||
          got.ip_address != want.ip_address || got.port_number != want.port_number ||
          got.error_total != want.error_total)
        report_mismatch("field", want, got);
    endtask

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic      clk          = 1'b0;
  logic      rst          = 1'b1;
  logic      byte_valid   = 1'b0;
  in_item_t  byte_data    = '0;
  logic      result_stall = 1'b0;
  logic      byte_stall;
  logic      result_valid;
  out_item_t result_data;

  addr_port_scoreboard sb = new();

  int         idle_pct    = 0;
  int         stall_pct   = 0;
  int         items_sent  = 0;
  int         payloads    = 0;
  int         cycle_count = 0;
  int         hold_tokens = 0;
  int         hold_taken  = 0;
  int         hold_left   = 0;
  logic [7:0] pay_q [$];
  logic [1:0] pay_op;

  ftp_address_port_parser_top uut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_data    (byte_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: check accepted items, then pick next cycle's stall
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result_data);
    if (hold_tokens != hold_taken) begin
      hold_taken = hold_tokens;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left     = hold_left - 1;
    end else begin
      result_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic send_item(in_item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_data  <= it;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    sb.take_byte(it);
    items_sent++;
  endtask

  // later bytes carry a random kind; only the first byte's kind counts
  task automatic send_payload();
    in_item_t it;
    for (int k = 0; k < pay_q.size(); k++) begin
      it.byte_value = pay_q[k];
      it.operation  = (k == 0) ? pay_op : 2'($urandom_range(0, 3));
      it.last_byte  = (k == pay_q.size() - 1);
      send_item(it);
    end
    payloads++;
  endtask

  task automatic send_text(logic [1:0] op, string s);
    pay_q = {};
    for (int k = 0; k < s.len(); k++) pay_q.push_back(s[k]);
    pay_op = op;
    send_payload();
  endtask

  task automatic push_decimal(logic [31:0] v);
    logic [7:0] dig [$];
    dig = {};
    if ($urandom_range(0, 9) == 0) pay_q.push_back(CH_ZERO);
    do begin
      dig.push_front(CH_ZERO + 8'(v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (dig[k]) pay_q.push_back(dig[k]);
  endtask

  function automatic logic [31:0] rand_field();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return 32'd0;
      2:       return 32'd255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic logic [31:0] rand_port();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return $urandom_range(65536, 999999);
      default: return $urandom_range(1, 65535);
    endcase
  endfunction

  function automatic logic [7:0] rand_delim();
    logic [7:0] d;
    d = 8'($urandom_range(33, 126));
    if ($urandom_range(0, 1) == 0 || (d >= CH_ZERO && d <= CH_NINE)) d = CH_BAR;
    return d;
  endfunction

  task automatic make_payload();
    int         r;
    int         cut;
    logic [7:0] d;
    pay_q  = {};
    pay_op = 2'($urandom_range(0, 3));
    r      = $urandom_range(0, 99);
    if (r >= 85) begin
      repeat ($urandom_range(1, 12)) pay_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      case (pay_op)
        OP_PORT: begin
          for (int k = 0; k < 6; k++) begin
            push_decimal(rand_field());
            if (k < 5) pay_q.push_back(CH_COMMA);
          end
          pay_q.push_back(CH_CR);
        end
        OP_PASV: begin
          repeat ($urandom_range(0, 6)) begin
            d = 8'($urandom_range(32, 126));
            if (d >= CH_ZERO && d <= CH_NINE) d = CH_LPAREN;
            pay_q.push_back(d);
          end
          for (int k = 0; k < 6; k++) begin
            push_decimal(rand_field());
            if (k < 5) pay_q.push_back(CH_COMMA);
          end
          d = 8'($urandom_range(0, 255));
          if ((d >= CH_ZERO && d <= CH_NINE) || d == CH_COMMA) d = CH_RPAREN;
          pay_q.push_back(d);
        end
        default: begin
          d = rand_delim();
          pay_q.push_back(d);
          if (pay_op == OP_EPRT) begin
            pay_q.push_back(($urandom_range(0, 9) == 0) ? CH_TWO : CH_ONE);
            pay_q.push_back(d);
            for (int k = 0; k < 4; k++) begin
              push_decimal(rand_field());
              if (k < 3) pay_q.push_back(CH_DOT);
            end
          end else begin
            pay_q.push_back(d);
          end
          pay_q.push_back(d);
          push_decimal(rand_port());
          pay_q.push_back(d);
        end
      endcase
      // junk after a finished parse is ignored by the block
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) pay_q.push_back(8'($urandom_range(0, 255)));
      if (r >= 70) begin
        if ($urandom_range(0, 1) == 0) begin
          pay_q[$urandom_range(0, pay_q.size() - 1)] = 8'($urandom_range(0, 255));
        end else begin
          cut = $urandom_range(1, pay_q.size());
          while (pay_q.size() > cut) void'(pay_q.pop_back());
        end
      end
    end
  endtask

  task automatic drain();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic run_phase(int s_idle, int r_stall, int n_items, bit long_hold);
    int target;
    idle_pct  = s_idle;
    stall_pct = r_stall;
    target    = items_sent + n_items;
    if (long_hold) hold_tokens++;
    while (items_sent < target) begin
      make_payload();
      send_payload();
    end
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // short directed payloads: early ends, bad heads, ipv6, extra commas, zero port
    send_text(OP_PORT, "\015");
    send_text(OP_EPSV, "|");
    send_text(OP_EPRT, "0");
    send_text(OP_EPRT, "|2|x");
    send_text(OP_PORT, ",,,,,,x");
    send_text(OP_EPSV, "|||0|");
    send_text(OP_EPSV, "!!!7!");
    pay_q  = {8'h00, 8'hFF};
    pay_op = OP_PASV;
    send_payload();
    drain();

    run_phase(0, 0, 300, 1'b0);
    run_phase(74, 0, 390, 1'b0);
    run_phase(0, 74, 390, 1'b1);
    run_phase(17, 17, 470, 1'b0);

    repeat (10) @(posedge clk);
    $display("Sent %0d bytes in %0d payloads; checked %0d results",
             items_sent, payloads, sb.results_seen);
    $display("(ok %0d, counted %0d, failed %0d, ipv6 %0d) over free flow, sender gaps,",
             sb.status_hits[ST_OK], sb.status_hits[ST_COUNTED],
             sb.status_hits[ST_FAIL], sb.status_hits[ST_IPV6]);
    $display("receiver stalls, a %0d-cycle hold-off and drained pauses.", HOLD_CYCLES);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
